// File: rtl/core/fatc_pkg.sv
// Shared types and codes for the FAT12 file read address engine.
// Holds item kinds, status codes, register slots, the descriptor record,
// and the sequencer state encoding. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fatc_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EOF       = 3'd1;
  localparam logic [2:0] ST_END_CHAIN = 3'd2;
  localparam logic [2:0] ST_BAD_DESC  = 3'd3;
  localparam logic [2:0] ST_NO_FREE   = 3'd4;

  localparam logic [1:0] REG_BYTES_PER_SECTOR    = 2'd0;
  localparam logic [1:0] REG_SECTORS_PER_CLUSTER = 2'd1;
  localparam logic [1:0] REG_DATA_REGION_START   = 2'd2;

  localparam logic [12:0] BPS_RESET = 13'd512;
  localparam logic [6:0]  SPC_RESET = 7'd1;
  localparam logic [24:0] DRS_RESET = 25'd16896;

  localparam logic [11:0] CHAIN_END_MIN = 12'hFF8;

  typedef struct packed {
    logic [11:0] cluster;
    logic [18:0] offset;
    logic [31:0] bytes_done;
    logic [31:0] size;
  } desc_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic use_set;
    logic use_clr;
  } desc_op_t;

  typedef struct packed {
    logic        en;
    logic [12:0] idx;
    logic [7:0]  data;
  } fat_wr_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DESC = 6'b000010,
    S_FAT  = 6'b000100,
    S_MUL  = 6'b001000,
    S_WB   = 6'b010000,
    S_RES  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/fatc_fat_mem.sv
// FAT copy split into even and odd byte banks, one synchronous read each.
// A chain lookup fetches both bytes of a 12-bit entry in parallel and unpacks it.
// Depends on fatc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fatc_fat_mem #(
  parameter int FAT_BYTES = 8192
) (
  input  wire logic             clk,
  input  wire fatc_pkg::fat_wr_t wr,
  input  wire logic             rd_en,
  input  wire logic [11:0]      rd_cluster,
  output logic      [11:0]      entry
);

  localparam int EVEN_DEPTH = (FAT_BYTES + 1) / 2;
  localparam int ODD_DEPTH  = FAT_BYTES / 2;
  localparam int FAW        = $clog2(EVEN_DEPTH);

  logic [7:0] even_bank [EVEN_DEPTH];
  logic [7:0] odd_bank  [ODD_DEPTH];

  logic [13:0]    pos;
  logic [13:0]    pos1;
  logic           lo_oob;
  logic           hi_oob;
  logic [FAW-1:0] even_addr;
  logic [FAW-1:0] odd_addr;
  logic           even_en;
  logic           odd_en;
  logic           wr_in_range;

  logic [7:0] even_q;
  logic [7:0] odd_q;
  logic       sel_q;
  logic       nib_q;
  logic       lo_oob_q;
  logic       hi_oob_q;
  logic [7:0] lo_byte;
  logic [7:0] hi_byte;
  logic [15:0] word;

  assign pos  = 14'({3'b0, rd_cluster[11:1]}) + 14'({2'b0, rd_cluster[11:1], 1'b0})
              + 14'(rd_cluster[0]);
  assign pos1 = pos + 14'd1;
  assign lo_oob = pos >= 14'(FAT_BYTES);
  assign hi_oob = pos1 >= 14'(FAT_BYTES);
  assign even_addr = pos[0] ? pos1[FAW:1] : pos[FAW:1];
  assign odd_addr  = pos[FAW:1];
  assign even_en = rd_en && (pos[0] ? !hi_oob : !lo_oob);
  assign odd_en  = rd_en && (pos[0] ? !lo_oob : !hi_oob);

  assign wr_in_range = {1'b0, wr.idx} < 14'(FAT_BYTES);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range && !wr.idx[0]) begin
      even_bank[wr.idx[FAW:1]] <= wr.data;
    end
    if (even_en) begin
      even_q <= even_bank[even_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range && wr.idx[0]) begin
      odd_bank[wr.idx[FAW:1]] <= wr.data;
    end
    if (odd_en) begin
      odd_q <= odd_bank[odd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sel_q    <= pos[0];
      nib_q    <= rd_cluster[0];
      lo_oob_q <= lo_oob;
      hi_oob_q <= hi_oob;
    end
  end

  assign lo_byte = lo_oob_q ? 8'hFF : (sel_q ? odd_q : even_q);
  assign hi_byte = hi_oob_q ? 8'hFF : (sel_q ? even_q : odd_q);
  assign word    = {hi_byte, lo_byte};
  assign entry   = nib_q ? word[15:4] : word[11:0];

endmodule

`default_nettype wire

// File: rtl/core/fatc_desc_mem.sv
// Descriptor record memory with one in-use flag per descriptor.
// Records are valid only while their flag is set; flags clear on reset.
// Depends on fatc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fatc_desc_mem #(
  parameter int NUM_DESCRIPTORS = 8,
  parameter int DW = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fatc_pkg::desc_op_t op,
  input  wire logic [DW-1:0]      idx,
  input  wire fatc_pkg::desc_t    wr_data,
  output fatc_pkg::desc_t         rd_data,
  output logic                    rd_in_use,
  output logic                    free_found,
  output logic [DW-1:0]           free_idx
);

  fatc_pkg::desc_t mem [NUM_DESCRIPTORS];
  logic [NUM_DESCRIPTORS-1:0] in_use;

  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[idx] <= wr_data;
    end
    if (op.rd) begin
      rd_data   <= mem[idx];
      rd_in_use <= in_use[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else begin
      if (op.use_set) begin
        in_use[idx] <= 1'b1;
      end
      if (op.use_clr) begin
        in_use[idx] <= 1'b0;
      end
    end
  end

  // lowest free slot wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_DESCRIPTORS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = DW'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fat12_file_read_address_engine.sv
// FAT12 file read address engine: top level with sequencer and register port.
// Depends on fatc_pkg, fatc_fat_mem and fatc_desc_mem.
//
// Usage: items arrive on item_valid/item_stall with fields kind, descriptor,
// fat_byte_index, fat_byte, start_cluster and file_size; each item produces
// exactly one result beat on result_valid/result_stall carrying status,
// granted_descriptor and byte_address. Registers bytes_per_sector,
// sectors_per_cluster and data_region_start sit at byte addresses 0, 4, 8
// of the APB port. The user must write them only while the engine is idle;
// the engine itself does not enforce this. One item is processed at a time.
// FAT loads, opens and closes go from idle straight to the result step; a
// read within the current cluster passes descriptor read and write back; a
// read that follows the chain passes descriptor read, FAT read, multiply and
// write back; a read that hits the end of the chain passes descriptor read and
// FAT read, then the result step. The result sits in an output register, so
// the next item is accepted while the previous result waits; the engine holds
// in its final step when the receiver stalls with a full output register.
// Reset frees all descriptors and drops result_valid; FAT contents are
// undefined until loaded, and registers return to 512, 1 and 16896.
`timescale 1ns / 1ps
`default_nettype none

module fat12_file_read_address_engine #(
  parameter int NUM_DESCRIPTORS = 8,
  parameter int FAT_BYTES = 8192
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [2:0]  descriptor,
  input  wire logic [12:0] fat_byte_index,
  input  wire logic [7:0]  fat_byte,
  input  wire logic [11:0] start_cluster,
  input  wire logic [31:0] file_size,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic      [2:0]  status,
  output logic      [2:0]  granted_descriptor,
  output logic      [24:0] byte_address
);

  localparam int DW = (NUM_DESCRIPTORS > 1) ? $clog2(NUM_DESCRIPTORS) : 1;

  logic [12:0] bytes_per_sector;
  logic [6:0]  sectors_per_cluster;
  logic [24:0] data_region_start;
  logic [19:0] bpc;
  logic        cfg_write;

  fatc_pkg::state_t state;
  fatc_pkg::state_t state_next;

  logic        item_accept;
  logic        out_free;
  logic        out_load;
  logic        d_ok;
  logic        desc_live;
  logic        eof;
  logic        need_chain;
  logic        chain_end;

  fatc_pkg::desc_op_t desc_op;
  logic [DW-1:0]      desc_idx;
  fatc_pkg::desc_t    desc_wdata;
  fatc_pkg::desc_t    desc_q;
  logic               desc_q_in_use;
  logic               free_found;
  logic [DW-1:0]      free_idx;

  fatc_pkg::fat_wr_t fat_wr;
  logic              fat_rd_en;
  logic [11:0]       fat_entry;

  logic        item_bad;
  logic [DW-1:0] cur_idx;
  logic [11:0] cur_cluster;
  logic [18:0] cur_offset;
  logic [31:0] cur_bytes;
  logic [31:0] cur_size;
  logic [24:0] prod;
  logic [2:0]  res_status;
  logic [2:0]  res_granted;

  logic [11:0] mult_cluster;
  logic [12:0] cl_m2;
  logic signed [33:0] prod_full;
  logic [24:0] addr_sum;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_sector    <= fatc_pkg::BPS_RESET;
      sectors_per_cluster <= fatc_pkg::SPC_RESET;
      data_region_start   <= fatc_pkg::DRS_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        fatc_pkg::REG_BYTES_PER_SECTOR:    bytes_per_sector    <= pwdata[12:0];
        fatc_pkg::REG_SECTORS_PER_CLUSTER: sectors_per_cluster <= pwdata[6:0];
        fatc_pkg::REG_DATA_REGION_START:   data_region_start   <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fatc_pkg::REG_BYTES_PER_SECTOR:    prdata = {19'b0, bytes_per_sector};
      fatc_pkg::REG_SECTORS_PER_CLUSTER: prdata = {25'b0, sectors_per_cluster};
      fatc_pkg::REG_DATA_REGION_START:   prdata = {7'b0, data_region_start};
      default:                           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    bpc <= 20'(bytes_per_sector * sectors_per_cluster);
  end

  // Memories
  fatc_fat_mem #(
    .FAT_BYTES(FAT_BYTES)
  ) u_fat_mem (
    .clk       (clk),
    .wr        (fat_wr),
    .rd_en     (fat_rd_en),
    .rd_cluster(desc_q.cluster),
    .entry     (fat_entry)
  );

  fatc_desc_mem #(
    .NUM_DESCRIPTORS(NUM_DESCRIPTORS),
    .DW             (DW)
  ) u_desc_mem (
    .clk       (clk),
    .rst       (rst),
    .op        (desc_op),
    .idx       (desc_idx),
    .wr_data   (desc_wdata),
    .rd_data   (desc_q),
    .rd_in_use (desc_q_in_use),
    .free_found(free_found),
    .free_idx  (free_idx)
  );

  // Decode
  assign item_stall  = (state != fatc_pkg::S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign out_free    = !result_valid || !result_stall;
  assign out_load    = out_free && (state == fatc_pkg::S_WB || state == fatc_pkg::S_RES);
  assign d_ok        = {29'b0, descriptor} < 32'(NUM_DESCRIPTORS);
  assign desc_live   = !item_bad && desc_q_in_use;
  assign eof         = desc_q.bytes_done >= desc_q.size;
  assign need_chain  = 20'(desc_q.offset) >= bpc;
  assign chain_end   = fat_entry >= fatc_pkg::CHAIN_END_MIN;

  // Cluster base: (cluster - 2) * bytes per cluster, modulo the address width
  assign mult_cluster = (state == fatc_pkg::S_DESC) ? desc_q.cluster : cur_cluster;
  assign cl_m2        = {1'b0, mult_cluster} - 13'd2;
  assign prod_full    = 34'($signed(cl_m2) * $signed({1'b0, bpc}));
  assign addr_sum     = data_region_start + prod + 25'(cur_offset);

  always_comb begin
    state_next = state;
    case (state)
      fatc_pkg::S_IDLE: begin
        if (item_accept) begin
          state_next = (kind == fatc_pkg::KIND_READ) ? fatc_pkg::S_DESC : fatc_pkg::S_RES;
        end
      end
      fatc_pkg::S_DESC: begin
        if (!desc_live || eof) begin
          state_next = fatc_pkg::S_RES;
        end else if (need_chain) begin
          state_next = fatc_pkg::S_FAT;
        end else begin
          state_next = fatc_pkg::S_WB;
        end
      end
      fatc_pkg::S_FAT: state_next = chain_end ? fatc_pkg::S_RES : fatc_pkg::S_MUL;
      fatc_pkg::S_MUL: state_next = fatc_pkg::S_WB;
      fatc_pkg::S_WB,
      fatc_pkg::S_RES: begin
        if (out_free) begin
          state_next = fatc_pkg::S_IDLE;
        end
      end
      default: state_next = fatc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    desc_op    = '0;
    desc_idx   = cur_idx;
    desc_wdata = '{cluster:    cur_cluster,
                   offset:     cur_offset + 19'd1,
                   bytes_done: cur_bytes + 32'd1,
                   size:       cur_size};
    fat_wr     = '{en: 1'b0, idx: fat_byte_index, data: fat_byte};
    fat_rd_en  = 1'b0;
    case (state)
      fatc_pkg::S_IDLE: begin
        if (item_accept) begin
          case (kind)
            fatc_pkg::KIND_LOAD: fat_wr.en = 1'b1;
            fatc_pkg::KIND_OPEN: begin
              desc_op.wr      = free_found;
              desc_op.use_set = free_found;
              desc_idx        = free_idx;
              desc_wdata      = '{cluster: start_cluster, offset: '0,
                                  bytes_done: '0, size: file_size};
            end
            fatc_pkg::KIND_READ: begin
              desc_op.rd = d_ok;
              desc_idx   = DW'(descriptor);
            end
            fatc_pkg::KIND_CLOSE: begin
              desc_op.use_clr = d_ok;
              desc_idx        = DW'(descriptor);
            end
            default: ;
          endcase
        end
      end
      fatc_pkg::S_DESC: fat_rd_en = desc_live && !eof && need_chain;
      fatc_pkg::S_WB:   desc_op.wr = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fatc_pkg::S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fatc_pkg::S_IDLE: begin
        if (item_accept) begin
          cur_idx  <= DW'(descriptor);
          item_bad <= !d_ok;
          if (kind == fatc_pkg::KIND_OPEN && !free_found) begin
            res_status <= fatc_pkg::ST_NO_FREE;
          end else if (kind == fatc_pkg::KIND_CLOSE && !d_ok) begin
            res_status <= fatc_pkg::ST_BAD_DESC;
          end else begin
            res_status <= fatc_pkg::ST_OK;
          end
          if (kind == fatc_pkg::KIND_OPEN && free_found) begin
            res_granted <= 3'(free_idx);
          end else begin
            res_granted <= 3'd0;
          end
        end
      end
      fatc_pkg::S_DESC: begin
        if (!desc_live) begin
          res_status <= fatc_pkg::ST_BAD_DESC;
        end else if (eof) begin
          res_status <= fatc_pkg::ST_EOF;
        end
        cur_cluster <= desc_q.cluster;
        cur_offset  <= desc_q.offset;
        cur_bytes   <= desc_q.bytes_done;
        cur_size    <= desc_q.size;
        prod        <= prod_full[24:0];
      end
      fatc_pkg::S_FAT: begin
        if (chain_end) begin
          res_status <= fatc_pkg::ST_END_CHAIN;
        end
        cur_cluster <= fat_entry;
        cur_offset  <= '0;
      end
      fatc_pkg::S_MUL: prod <= prod_full[24:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == fatc_pkg::S_WB) begin
        status             <= fatc_pkg::ST_OK;
        granted_descriptor <= 3'd0;
        byte_address       <= addr_sum;
      end else begin
        status             <= res_status;
        granted_descriptor <= res_granted;
        byte_address       <= '0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !(result_valid && result_stall))
    else $error("result register loaded while a stalled beat is pending");

  a_read_to_desc: assert property (@(posedge clk) disable iff (rst)
    (item_accept && kind == fatc_pkg::KIND_READ) |=> state == fatc_pkg::S_DESC)
    else $error("accepted read did not move to descriptor fetch");

  a_fat_after_desc: assert property (@(posedge clk) disable iff (rst)
    state == fatc_pkg::S_FAT |-> $past(state) == fatc_pkg::S_DESC)
    else $error("FAT lookup entered without a descriptor fetch");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking bench for the FAT12 file read address engine.
// Holds the descriptor/FAT predictor, the item and APB drivers, and the result checker.
// Depends on fatc_pkg and fat12_file_read_address_engine.
`timescale 1ns / 1ps

module tb_top;

  localparam int NDESC = 8;
  localparam int FAT_SIZE = 8192;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    fatc_pkg::kind_t kind;
    logic [2:0]  desc;
    logic [12:0] fidx;
    logic [7:0]  fbyte;
    logic [11:0] first;
    logic [31:0] fsize;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  granted;
    logic [24:0] addr;
  } outcome_t;

  class fat_scoreboard;
    logic [7:0]  fat_mem [FAT_SIZE];
    bit          fat_known [FAT_SIZE];
    bit          open_flag [NDESC];
    logic [11:0] cur_cluster [NDESC];
    logic [18:0] cur_offset [NDESC];
    logic [31:0] bytes_done [NDESC];
    logic [31:0] file_len [NDESC];
    logic [12:0] sector_bytes;
    logic [6:0]  cluster_sectors;
    logic [24:0] data_base;
    outcome_t    awaited [$];
    int          errors;

    function new();
      for (int i = 0; i < FAT_SIZE; i++) begin
        fat_mem[i] = 8'd0;
        fat_known[i] = 1'b0;
      end
      for (int k = 0; k < NDESC; k++) drop_desc(k);
      sector_bytes = fatc_pkg::BPS_RESET;
      cluster_sectors = fatc_pkg::SPC_RESET;
      data_base = fatc_pkg::DRS_RESET;
      errors = 0;
    endfunction

    function void drop_desc(int k);
      open_flag[k] = 1'b0;
      cur_cluster[k] = 12'd0;
      cur_offset[k] = 19'd0;
      bytes_done[k] = 32'd0;
      file_len[k] = 32'd0;
    endfunction

    function logic [19:0] cluster_bytes();
      logic [19:0] bps;
      logic [19:0] spc;
      bps = {7'd0, sector_bytes};
      spc = {13'd0, cluster_sectors};
      return bps * spc;
    endfunction

    function int entry_pos(logic [11:0] c);
      return (int'(c) / 2) * 3 + int'(c) % 2;
    endfunction

    function logic [11:0] fat_entry(logic [11:0] c);
      int pos;
      logic [15:0] word;
      pos = entry_pos(c);
      word = {fat_mem[pos + 1], fat_mem[pos]};
      return c[0] ? word[15:4] : word[11:0];
    endfunction

    // cluster whose FAT entry a read on d would unpack from unloaded bytes, else -1
    function int gap_cluster(logic [2:0] d);
      int pos;
      if (!open_flag[d] || bytes_done[d] >= file_len[d]) return -1;
      if ({1'b0, cur_offset[d]} < cluster_bytes()) return -1;
      pos = entry_pos(cur_cluster[d]);
      if (fat_known[pos] && fat_known[pos + 1]) return -1;
      return int'(cur_cluster[d]);
    endfunction

    function void set_reg(logic [1:0] slot, logic [31:0] v);
      case (slot)
        fatc_pkg::REG_BYTES_PER_SECTOR:    sector_bytes = v[12:0];
        fatc_pkg::REG_SECTORS_PER_CLUSTER: cluster_sectors = v[6:0];
        fatc_pkg::REG_DATA_REGION_START:   data_base = v[24:0];
        default: ;
      endcase
    endfunction

    function void note_item(item_t it);
      outcome_t r;
      logic [11:0] nxt;
      logic [63:0] base, clus, bpc, off, a;
      bit found;
      bit go;
      r.status = fatc_pkg::ST_OK;
      r.granted = 3'd0;
      r.addr = 25'd0;
      case (it.kind)
        fatc_pkg::KIND_LOAD: begin
          fat_mem[it.fidx] = it.fbyte;
          fat_known[it.fidx] = 1'b1;
        end
        fatc_pkg::KIND_OPEN: begin
          found = 1'b0;
          for (int k = 0; k < NDESC && !found; k++) begin
            if (!open_flag[k]) begin
              found = 1'b1;
              drop_desc(k);
              open_flag[k] = 1'b1;
              cur_cluster[k] = it.first;
              file_len[k] = it.fsize;
              r.granted = k[2:0];
            end
          end
          if (!found) r.status = fatc_pkg::ST_NO_FREE;
        end
        fatc_pkg::KIND_READ: begin
          if (!open_flag[it.desc]) begin
            r.status = fatc_pkg::ST_BAD_DESC;
          end else if (bytes_done[it.desc] >= file_len[it.desc]) begin
            r.status = fatc_pkg::ST_EOF;
          end else begin
            go = 1'b1;
            if ({1'b0, cur_offset[it.desc]} >= cluster_bytes()) begin
              nxt = fat_entry(cur_cluster[it.desc]);
              if (nxt >= fatc_pkg::CHAIN_END_MIN) begin
                r.status = fatc_pkg::ST_END_CHAIN;
                go = 1'b0;
              end else begin
                cur_cluster[it.desc] = nxt;
                cur_offset[it.desc] = 19'd0;
              end
            end
            if (go) begin
              base = {39'd0, data_base};
              clus = {52'd0, cur_cluster[it.desc]};
              bpc = {44'd0, cluster_bytes()};
              off = {45'd0, cur_offset[it.desc]};
              a = base + (clus - 64'd2) * bpc + off;
              r.addr = a[24:0];
              cur_offset[it.desc] = cur_offset[it.desc] + 19'd1;
              bytes_done[it.desc] = bytes_done[it.desc] + 32'd1;
            end
          end
        end
        default: drop_desc(int'(it.desc));
      endcase
      awaited.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        if (errors < 40)
          $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] st, logic [2:0] gd, logic [24:0] ad);
      outcome_t want;
      if (awaited.size() == 0) begin
        if (errors < 40)
          $display("%0t: unexpected beat: expected none actual status %0d addr %0d",
                   $time, st, ad);
        errors++;
        return;
      end
      want = awaited.pop_front();
      report("status", {29'd0, want.status}, {29'd0, st});
      report("granted_descriptor", {29'd0, want.granted}, {29'd0, gd});
      report("byte_address", {7'd0, want.addr}, {7'd0, ad});
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  kind;
  logic [2:0]  descriptor;
  logic [12:0] fat_byte_index;
  logic [7:0]  fat_byte;
  logic [11:0] start_cluster;
  logic [31:0] file_size;
  logic        result_valid;
  logic        result_stall;
  logic [2:0]  status;
  logic [2:0]  granted_descriptor;
  logic [24:0] byte_address;

  fat_scoreboard sb;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int            quiet;

  fat12_file_read_address_engine #(
    .NUM_DESCRIPTORS(NDESC),
    .FAT_BYTES(FAT_SIZE)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .descriptor(descriptor),
    .fat_byte_index(fat_byte_index),
    .fat_byte(fat_byte),
    .start_cluster(start_cluster),
    .file_size(file_size),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .status(status),
    .granted_descriptor(granted_descriptor),
    .byte_address(byte_address)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    result_stall = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (result_valid && !result_stall)
        sb.check_result(status, granted_descriptor, byte_address);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  function automatic item_t noise(fatc_pkg::kind_t k);
    item_t it;
    int unsigned pick;
    pick = $urandom;
    it.kind = k;
    it.desc = pick[2:0];
    it.fidx = pick[15:3];
    it.fbyte = pick[23:16];
    pick = $urandom;
    it.first = pick[11:0];
    it.fsize = $urandom;
    return it;
  endfunction

  function automatic item_t build(fatc_pkg::kind_t k, logic [2:0] d, logic [12:0] a,
                                  logic [31:0] b);
    item_t it;
    it = noise(k);
    it.desc = d;
    if (k == fatc_pkg::KIND_LOAD) begin
      it.fidx = a;
      it.fbyte = b[7:0];
    end else if (k == fatc_pkg::KIND_OPEN) begin
      it.first = a[11:0];
      it.fsize = b;
    end
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int live [$];
    int unsigned r;
    int unsigned pick;
    for (int k = 0; k < NDESC; k++)
      if (sb.open_flag[k]) live.push_back(k);
    r = $urandom_range(99);
    if (r < 15) it = noise(fatc_pkg::KIND_LOAD);
    else if (r < 28) it = noise(fatc_pkg::KIND_OPEN);
    else if (r < 37) it = noise(fatc_pkg::KIND_CLOSE);
    else it = noise(fatc_pkg::KIND_READ);
    if (live.size() > 0 && $urandom_range(99) < 85) begin
      pick = live[$urandom_range(live.size() - 1)];
      it.desc = pick[2:0];
    end
    if (it.kind == fatc_pkg::KIND_OPEN) begin
      if ($urandom_range(99) < 75) begin
        pick = $urandom_range(4087, 2);
        it.first = pick[11:0];
      end
      r = $urandom_range(99);
      if (r < 50) it.fsize = $urandom_range(40);
      else if (r < 70) it.fsize = $urandom_range(600);
      else if (r < 80) it.fsize = 32'd0;
      else if (r < 90) it.fsize = 32'hFFFF_FFFF;
    end
    return it;
  endfunction

  task automatic push_beat(input item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    kind = it.kind;
    descriptor = it.desc;
    fat_byte_index = it.fidx;
    fat_byte = it.fbyte;
    start_cluster = it.first;
    file_size = it.fsize;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  // load both bytes of a FAT entry, keeping the neighbor's nibble
  task automatic fill_entry(input logic [11:0] c);
    int pos;
    int unsigned pick;
    logic [11:0] val;
    logic [7:0] keep, lo, hi;
    pick = $urandom_range(99);
    if (pick < 30) pick = $urandom_range(4095, 4088);
    else if (pick < 36) pick = $urandom_range(1);
    else pick = $urandom_range(4087, 2);
    val = pick[11:0];
    pos = sb.entry_pos(c);
    pick = $urandom;
    if (c[0]) begin
      keep = sb.fat_known[pos] ? sb.fat_mem[pos] : pick[7:0];
      lo = {val[3:0], keep[3:0]};
      hi = val[11:4];
    end else begin
      keep = sb.fat_known[pos + 1] ? sb.fat_mem[pos + 1] : pick[7:0];
      lo = val[7:0];
      hi = {keep[7:4], val[11:8]};
    end
    push_beat(build(fatc_pkg::KIND_LOAD, pick[10:8], pos[12:0], {24'd0, lo}));
    pos = pos + 1;
    push_beat(build(fatc_pkg::KIND_LOAD, pick[13:11], pos[12:0], {24'd0, hi}));
  endtask

  task automatic send_item(input item_t it);
    int c;
    if (it.kind == fatc_pkg::KIND_READ) begin
      c = sb.gap_cluster(it.desc);
      while (c >= 0) begin
        fill_entry(c[11:0]);
        c = sb.gap_cluster(it.desc);
      end
    end
    push_beat(it);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] slot, input logic [31:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {slot, 2'b00};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(slot, v);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  initial begin
    int unsigned bps, spc, drs;
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    item_valid = 1'b0;
    kind = fatc_pkg::KIND_LOAD;
    descriptor = 3'd0;
    fat_byte_index = 13'd0;
    fat_byte = 8'd0;
    start_cluster = 12'd0;
    file_size = 32'd0;
    result_stall = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(build(fatc_pkg::KIND_LOAD, 3'd0, 13'd0, 32'h00));
    send_item(build(fatc_pkg::KIND_LOAD, 3'd7, 13'h1FFF, 32'hFF));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'd2, 32'd0));
    send_item(build(fatc_pkg::KIND_READ, 3'd0, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_READ, 3'd6, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_CLOSE, 3'd7, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'hFFF, 32'hFFFF_FFFF));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'd0, 32'd5));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'd1, 32'd3));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'd4087, 32'd1));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'hAAA, 32'd100));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'h555, 32'd2));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'd3, 32'd1));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'd2, 32'd1));
    send_item(build(fatc_pkg::KIND_READ, 3'd1, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_READ, 3'd2, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_READ, 3'd3, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_READ, 3'd4, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_READ, 3'd4, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_CLOSE, 3'd4, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_OPEN, 3'd0, 13'd100, 32'd7));
    send_item(build(fatc_pkg::KIND_READ, 3'd7, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_READ, 3'd7, 13'd0, 32'd0));
    send_item(build(fatc_pkg::KIND_CLOSE, 3'd0, 13'd0, 32'd0));
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      drs = $urandom & 32'h01FF_FFFF;
      case (phase)
        0: begin bps = 1;    spc = 1;   drs = 32'h01FF_FFFF; end
        1: begin bps = 8191; spc = 127; drs = 0;             end
        2: begin bps = 0;    spc = $urandom_range(127);      end
        3: begin bps = $urandom_range(8, 1); spc = $urandom_range(4, 1); end
        4: begin bps = 4096; spc = 64;  end
        5: begin bps = 128;  spc = 1;   end
        6: begin bps = $urandom_range(8191); spc = $urandom_range(127); end
        default: begin bps = 2; spc = 3; end
      endcase
      reg_write(fatc_pkg::REG_BYTES_PER_SECTOR, bps);
      reg_write(fatc_pkg::REG_SECTORS_PER_CLUSTER, spc);
      reg_write(fatc_pkg::REG_DATA_REGION_START, drs);
      repeat (185) send_item(random_item());
      drain();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
